// ----- hw/rtl/array_doubly_linked_list_core_macros.svh -----
// Assertion macros for the array doubly linked list core.
// Each macro expects the signals clk and rst to be in scope where it is used.
`ifndef ARRAY_DOUBLY_LINKED_LIST_CORE_MACROS_SVH
`define ARRAY_DOUBLY_LINKED_LIST_CORE_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ADLL_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ADLL_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/adll_pkg.sv -----
// Shared constants and types for the array doubly linked list core.
// No dependencies; imported by the core.
package adll_pkg;

  localparam int NODE_SLOTS = 1024;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(NODE_SLOTS);

  typedef logic [IDX_W-1:0]      node_idx_t;
  typedef logic [VALUE_BITS-1:0] node_val_t;
  typedef logic [2:0]            func_t;
  typedef logic [1:0]            status_t;

  // Command codes.
  localparam func_t FN_PUSH_HEAD = 3'd0;
  localparam func_t FN_PUSH_TAIL = 3'd1;
  localparam func_t FN_DELETE    = 3'd2;
  localparam func_t FN_INS_LEFT  = 3'd3;
  localparam func_t FN_INS_RIGHT = 3'd4;
  localparam func_t FN_READ      = 3'd5;

  // Status codes.
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_NOT_LIVE = 2'd2;

  localparam node_idx_t NULL_NODE  = '0;
  localparam node_idx_t ALLOC_LAST = node_idx_t'(NODE_SLOTS - 1);

  // One write request to a link memory.
  typedef struct packed {
    logic      en;
    node_idx_t addr;
    node_idx_t data;
  } link_wr_t;

endpackage

// ----- hw/rtl/array_doubly_linked_list_core.sv -----
// Top level of the array doubly linked list core: control, registers and node memories.
// Depends on adll_pkg, adll_ram and array_doubly_linked_list_core_macros.svh.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    func, node, item_value
//   out      output     out_valid / out_ready  new_node, read_value, read_prev, read_next,
//                                              head_node, tail_node, live_count, status
//
// A command is read from the node memories in its accept cycle and resolved in S_EXEC:
// delete, read, unused and rejected commands and pushes onto an empty list then return to
// idle; other creates pass through S_LINK, which writes the neighbour links.
// Reset clears head, tail, count and allocator; the memories need no clearing, as a slot
// is only treated as live when it lies at or below the allocator and its dead flag is low.
// A result waiting on out_ready stalls the next command in its resolve cycle only.
`include "array_doubly_linked_list_core_macros.svh"

module array_doubly_linked_list_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  adll_pkg::func_t   func,
  input  adll_pkg::node_idx_t node,
  input  adll_pkg::node_val_t item_value,
  output logic              out_valid,
  input  logic              out_ready,
  output adll_pkg::node_idx_t new_node,
  output adll_pkg::node_val_t read_value,
  output adll_pkg::node_idx_t read_prev,
  output adll_pkg::node_idx_t read_next,
  output adll_pkg::node_idx_t head_node,
  output adll_pkg::node_idx_t tail_node,
  output adll_pkg::node_idx_t live_count,
  output adll_pkg::status_t status
);

  import adll_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK
  } state_t;

  state_t    state;
  func_t     func_q;
  node_idx_t tgt_q;
  node_val_t val_q;
  node_idx_t head_q;
  node_idx_t tail_q;
  node_idx_t count_q;
  node_idx_t alloc_q;
  link_wr_t  prev_pend;
  link_wr_t  next_pend;

  // Memory read data for the target node.
  node_val_t rd_value;
  node_idx_t rd_prev;
  node_idx_t rd_next;
  logic [0:0] rd_dead;

  // Resolve-cycle results.
  node_idx_t head_next;
  node_idx_t tail_next;
  node_idx_t count_next;
  node_idx_t alloc_next;
  node_idx_t created;
  node_val_t rv;
  node_idx_t rp;
  node_idx_t rn;
  status_t   st;
  logic      create_en;
  logic      del_en;
  node_idx_t create_prev;
  node_idx_t create_next;
  link_wr_t  prev_w1;
  link_wr_t  next_w1;
  link_wr_t  prev_pend_next;
  link_wr_t  next_pend_next;
  logic      live;
  logic      can_alloc;
  node_idx_t new_idx;
  logic      exec_go;
  logic      link_need;

  // Memory write ports.
  link_wr_t   prev_wr;
  link_wr_t   next_wr;
  logic       val_we;
  logic       dead_we;
  node_idx_t  dead_waddr;
  logic [0:0] dead_wdata;
  logic       rd_en;
  logic       mem_we;

  assign in_ready = (state == S_IDLE) && !rst;
  assign rd_en    = in_valid && in_ready;
  assign exec_go  = (state == S_EXEC) && (!out_valid || out_ready);

  // Command decode against the node read in the accept cycle.
  always_comb begin
    head_next      = head_q;
    tail_next      = tail_q;
    count_next     = count_q;
    alloc_next     = alloc_q;
    created        = NULL_NODE;
    rv             = '0;
    rp             = NULL_NODE;
    rn             = NULL_NODE;
    st             = ST_OK;
    create_en      = 1'b0;
    del_en         = 1'b0;
    create_prev    = NULL_NODE;
    create_next    = NULL_NODE;
    prev_w1        = '0;
    next_w1        = '0;
    prev_pend_next = '0;
    next_pend_next = '0;
    live      = (tgt_q != NULL_NODE) && (tgt_q <= alloc_q) && !rd_dead[0];
    can_alloc = (alloc_q < ALLOC_LAST);
    new_idx   = alloc_q + 1'b1;

    unique case (func_q)
      FN_PUSH_HEAD: begin
        if (!can_alloc) begin
          st = ST_FULL;
        end else begin
          create_en   = 1'b1;
          create_next = head_q;
          if (head_q != NULL_NODE) begin
            prev_pend_next = '{1'b1, head_q, new_idx};
          end else begin
            tail_next = new_idx;
          end
          head_next = new_idx;
        end
      end
      FN_PUSH_TAIL: begin
        if (!can_alloc) begin
          st = ST_FULL;
        end else begin
          create_en   = 1'b1;
          create_prev = tail_q;
          if (tail_q != NULL_NODE) begin
            next_pend_next = '{1'b1, tail_q, new_idx};
          end else begin
            head_next = new_idx;
          end
          tail_next = new_idx;
        end
      end
      FN_DELETE: begin
        if (!live) begin
          st = ST_NOT_LIVE;
        end else begin
          del_en = 1'b1;
          if (rd_prev != NULL_NODE) begin
            next_w1 = '{1'b1, rd_prev, rd_next};
          end else begin
            head_next = rd_next;
          end
          if (rd_next != NULL_NODE) begin
            prev_w1 = '{1'b1, rd_next, rd_prev};
          end else begin
            tail_next = rd_prev;
          end
          count_next = count_q - 1'b1;
        end
      end
      FN_INS_LEFT: begin
        if (!live) begin
          st = ST_NOT_LIVE;
        end else if (!can_alloc) begin
          st = ST_FULL;
        end else begin
          create_en      = 1'b1;
          create_prev    = rd_prev;
          create_next    = tgt_q;
          prev_pend_next = '{1'b1, tgt_q, new_idx};
          if (rd_prev != NULL_NODE) begin
            next_pend_next = '{1'b1, rd_prev, new_idx};
          end else begin
            head_next = new_idx;
          end
        end
      end
      FN_INS_RIGHT: begin
        if (!live) begin
          st = ST_NOT_LIVE;
        end else if (!can_alloc) begin
          st = ST_FULL;
        end else begin
          create_en      = 1'b1;
          create_prev    = tgt_q;
          create_next    = rd_next;
          next_pend_next = '{1'b1, tgt_q, new_idx};
          if (rd_next != NULL_NODE) begin
            prev_pend_next = '{1'b1, rd_next, new_idx};
          end else begin
            tail_next = new_idx;
          end
        end
      end
      FN_READ: begin
        if (!live) begin
          st = ST_NOT_LIVE;
        end else begin
          rv = rd_value;
          rp = rd_prev;
          rn = rd_next;
        end
      end
      default: begin
      end
    endcase

    if (create_en) begin
      alloc_next = new_idx;
      count_next = count_q + 1'b1;
      created    = new_idx;
    end
    link_need = prev_pend_next.en || next_pend_next.en;
  end

  // Write port selection: the new node or delete splice first, the neighbour links after.
  always_comb begin
    prev_wr = '0;
    next_wr = '0;
    if (state == S_LINK) begin
      prev_wr = prev_pend;
      next_wr = next_pend;
    end else if (exec_go && create_en) begin
      prev_wr = '{1'b1, new_idx, create_prev};
      next_wr = '{1'b1, new_idx, create_next};
    end else if (exec_go) begin
      prev_wr = prev_w1;
      next_wr = next_w1;
    end
    val_we     = exec_go && create_en;
    dead_we    = exec_go && (create_en || del_en);
    dead_waddr = create_en ? new_idx : tgt_q;
    dead_wdata = del_en;
  end

  // Node memories, all read at the incoming target in the accept cycle.
  adll_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODE_SLOTS)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (new_idx),
    .wdata (val_q),
    .re    (rd_en),
    .raddr (node),
    .rdata (rd_value)
  );

  adll_ram #(.WIDTH(IDX_W), .DEPTH(NODE_SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_wr.en),
    .waddr (prev_wr.addr),
    .wdata (prev_wr.data),
    .re    (rd_en),
    .raddr (node),
    .rdata (rd_prev)
  );

  adll_ram #(.WIDTH(IDX_W), .DEPTH(NODE_SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (next_wr.en),
    .waddr (next_wr.addr),
    .wdata (next_wr.data),
    .re    (rd_en),
    .raddr (node),
    .rdata (rd_next)
  );

  adll_ram #(.WIDTH(1), .DEPTH(NODE_SLOTS)) u_dead_ram (
    .clk   (clk),
    .we    (dead_we),
    .waddr (dead_waddr),
    .wdata (dead_wdata),
    .re    (rd_en),
    .raddr (node),
    .rdata (rd_dead)
  );

  // Sequencer, list registers and the output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      head_q    <= NULL_NODE;
      tail_q    <= NULL_NODE;
      count_q   <= '0;
      alloc_q   <= NULL_NODE;
      prev_pend <= '0;
      next_pend <= '0;
    end else begin
      if (out_valid && out_ready && !exec_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q <= func;
            tgt_q  <= node;
            val_q  <= item_value;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            head_q     <= head_next;
            tail_q     <= tail_next;
            count_q    <= count_next;
            alloc_q    <= alloc_next;
            prev_pend  <= prev_pend_next;
            next_pend  <= next_pend_next;
            out_valid  <= 1'b1;
            new_node   <= created;
            read_value <= rv;
            read_prev  <= rp;
            read_next  <= rn;
            head_node  <= head_next;
            tail_node  <= tail_next;
            live_count <= count_next;
            status     <= st;
            state      <= link_need ? S_LINK : S_IDLE;
          end
        end
        S_LINK: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Any write into the node memories this cycle.
  assign mem_we = prev_wr.en || next_wr.en || val_we || dead_we;

  // The live count can never pass the number of slots ever handed out.
  `ADLL_ASSERT_ALWAYS(a_count_le_alloc, count_q <= alloc_q, "node count above allocator")
  // An empty list has null head and tail, and a non-empty one has neither null.
  `ADLL_ASSERT_ALWAYS(a_head_ends, (head_q == NULL_NODE) == (count_q == '0), "head vs count")
  `ADLL_ASSERT_ALWAYS(a_tail_ends, (tail_q == NULL_NODE) == (count_q == '0), "tail vs count")
  // Memories are never written while a new command may be reading them.
  `ADLL_ASSERT_IMPLY(a_no_write_idle, state == S_IDLE, !mem_we, "memory write in idle")
  // The allocator only ever steps by one.
  `ADLL_ASSERT_IMPLY(a_alloc_step, alloc_q != $past(alloc_q), alloc_q == $past(new_idx), "alloc jump")

endmodule

// ----- hw/rtl/adll_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read with enable; no dependencies.
module adll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
